[rtl/ssmt_pkg.sv]
// ----------------------------------------------------------------------------
// ssmt_pkg
// Shared types and constants for the sparse set membership table.
// ----------------------------------------------------------------------------
package ssmt_pkg;

   // fixed field widths of the ports
   localparam int CMD_W    = 2;
   localparam int HANDLE_W = 32;
   localparam int CFG_W    = 11;
   localparam int CSR_IDX_W = 1;
   localparam int POS_W    = 10;
   localparam int LIVE_W   = 11;

   // width that holds every index or capacity limit
   localparam int LIM_W = 17;

   // command codes
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTITY_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_CAPACITY = 1'd1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP_RD,
      ST_DENSE_RD,
      ST_LAST_RD,
      ST_MOVED_RD,
      ST_MAP_FIX,
      ST_FINISH
   } state_type;

   // datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_TAKE,
      OP_RD_SLOT,
      OP_HIT,
      OP_ADD,
      OP_DROP_LAST,
      OP_RD_LAST,
      OP_RD_MOVED,
      OP_SWAP,
      OP_UNMAP,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_free;
      logic cmd_query;
      logic cmd_add;
      logic cmd_remove;
      logic fits;
      logic enc_zero;
      logic hit_range;
      logic room;
      logic dense_match;
      logic slot_is_last;
      logic moved_fits;
      logic moved_map_ok;
   } dp_status_type;

endpackage

[rtl/sparse_set_membership_table_unit.sv]
// ----------------------------------------------------------------------------
// sparse_set_membership_table_unit
// Sparse set of generation-tagged handles with query, add and swap-remove.
// ----------------------------------------------------------------------------
//  port group   dir  handshake              payload
//  req_*        in   req_valid/req_stall    command, entity_handle
//  rsp_*        out  rsp_valid/rsp_stall    ok, positions, moved handle, count
//  csr_*        in   csr_write_enable       csr_index, csr_write_data
//
//  one word at a time: from acceptance to the result register a command
//  steps through a chain of dependent reads through the single read port
//  of each memory.
//  after reset a clearing pass zeroes the sparse map with req_stall high;
//  csr writes are taken during it.
//  the result register lets the next word in while a result waits on
//  rsp_stall; a second result waits in the sequencer until it drains.
// ----------------------------------------------------------------------------
module sparse_set_membership_table_unit #(
   parameter int ENTITY_CAP  = 1024,
   parameter int POOL_CAP    = 1024,
   parameter int INDEX_BITS  = 10,
   parameter int HANDLE_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ssmt_pkg::CMD_W-1:0]      req_command,
   input  logic [ssmt_pkg::HANDLE_W-1:0]   req_entity_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_ok,
   output logic [ssmt_pkg::POS_W-1:0]      rsp_dense_position,
   output logic [ssmt_pkg::POS_W-1:0]      rsp_moved_from_position,
   output logic [ssmt_pkg::HANDLE_W-1:0]   rsp_moved_handle,
   output logic [ssmt_pkg::LIVE_W-1:0]     rsp_live_count,
   input  logic                            csr_write_enable,
   input  logic [ssmt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssmt_pkg::CFG_W-1:0]      csr_write_data
);
   import ssmt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   ssmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // memories and result word
   ssmt_datapath #(
      .ENTITY_CAP  (ENTITY_CAP),
      .POOL_CAP    (POOL_CAP),
      .INDEX_BITS  (INDEX_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_command             (req_command),
      .req_entity_handle       (req_entity_handle),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_ok                  (rsp_ok),
      .rsp_dense_position      (rsp_dense_position),
      .rsp_moved_from_position (rsp_moved_from_position),
      .rsp_moved_handle        (rsp_moved_handle),
      .rsp_live_count          (rsp_live_count),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .cmd                     (cmd),
      .status                  (status)
   );

endmodule

[rtl/ssmt_ctrl.sv]
// ----------------------------------------------------------------------------
// ssmt_ctrl
// Sequencer for the table: clearing pass, lookup, add and swap-remove steps.
// ----------------------------------------------------------------------------
module ssmt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ssmt_pkg::dp_status_type status,
   output ssmt_pkg::dp_cmd_type  cmd
);
   import ssmt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath operation
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_TAKE;
               state_in = ST_MAP_RD;
            end
         end
         ST_MAP_RD: begin
            state_in = ST_FINISH;
            if (status.cmd_add) begin
               if (status.fits && status.room && status.enc_zero) begin
                  cmd.op = OP_ADD;
               end
            end else if (status.cmd_query || status.cmd_remove) begin
               if (status.fits && status.hit_range) begin
                  cmd.op   = OP_RD_SLOT;
                  state_in = ST_DENSE_RD;
               end
            end
         end
         ST_DENSE_RD: begin
            state_in = ST_FINISH;
            if (status.dense_match) begin
               if (status.cmd_query) begin
                  cmd.op = OP_HIT;
               end else if (status.slot_is_last) begin
                  cmd.op = OP_DROP_LAST;
               end else begin
                  cmd.op   = OP_RD_LAST;
                  state_in = ST_LAST_RD;
               end
            end
         end
         ST_LAST_RD: begin
            state_in = ST_FINISH;
            if (status.moved_fits) begin
               cmd.op   = OP_RD_MOVED;
               state_in = ST_MOVED_RD;
            end
         end
         ST_MOVED_RD: begin
            state_in = ST_FINISH;
            if (status.moved_map_ok) begin
               cmd.op   = OP_SWAP;
               state_in = ST_MAP_FIX;
            end
         end
         ST_MAP_FIX: begin
            cmd.op   = OP_UNMAP;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.op   = OP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/ssmt_datapath.sv]
// ----------------------------------------------------------------------------
// ssmt_datapath
// Sparse map and dense handle memories, live count, limits and result word.
// ----------------------------------------------------------------------------
module ssmt_datapath #(
   parameter int ENTITY_CAP  = 1024,
   parameter int POOL_CAP    = 1024,
   parameter int INDEX_BITS  = 10,
   parameter int HANDLE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ssmt_pkg::CMD_W-1:0]       req_command,
   input  logic [ssmt_pkg::HANDLE_W-1:0]    req_entity_handle,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic [ssmt_pkg::POS_W-1:0]       rsp_dense_position,
   output logic [ssmt_pkg::POS_W-1:0]       rsp_moved_from_position,
   output logic [ssmt_pkg::HANDLE_W-1:0]    rsp_moved_handle,
   output logic [ssmt_pkg::LIVE_W-1:0]      rsp_live_count,
   input  logic                             csr_write_enable,
   input  logic [ssmt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssmt_pkg::CFG_W-1:0]       csr_write_data,
   input  ssmt_pkg::dp_cmd_type             cmd,
   output ssmt_pkg::dp_status_type          status
);
   import ssmt_pkg::*;

   localparam int MAW    = (ENTITY_CAP > 1) ? $clog2(ENTITY_CAP) : 1;
   localparam int PW     = (POOL_CAP > 1) ? $clog2(POOL_CAP) : 1;
   localparam int CNT_W  = $clog2(POOL_CAP + 1);
   localparam int XW     = (INDEX_BITS > LIM_W) ? INDEX_BITS : LIM_W;
   localparam int IDX_LIM = (ENTITY_CAP < (1 << INDEX_BITS)) ? ENTITY_CAP
                                                            : (1 << INDEX_BITS);
   localparam logic [HANDLE_W-1:0] HMASK = (HANDLE_BITS >= HANDLE_W) ?
      {HANDLE_W{1'b1}} : HANDLE_W'((33'd1 << HANDLE_BITS) - 33'd1);

   // limit registers
   logic [CFG_W-1:0] entity_limit_ff;
   logic [CFG_W-1:0] pool_capacity_ff;

   // storage
   logic [CNT_W-1:0]    sparse_map_ff [ENTITY_CAP];
   logic [HANDLE_W-1:0] dense_handles_ff [POOL_CAP];
   logic [CNT_W-1:0]    map_rd_ff;
   logic [HANDLE_W-1:0] dense_rd_ff;

   // working registers
   logic [MAW-1:0]      clr_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [CNT_W-1:0]    slot_ff;
   logic [HANDLE_W-1:0] moved_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                res_ok_ff;
   logic [CNT_W-1:0]    res_pos_ff;
   logic [CNT_W-1:0]    res_from_ff;
   logic [HANDLE_W-1:0] res_moved_ff;

   // result word
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [POS_W-1:0]    rsp_pos_ff;
   logic [POS_W-1:0]    rsp_from_ff;
   logic [HANDLE_W-1:0] rsp_moved_ff;
   logic [LIVE_W-1:0]   rsp_live_ff;

   logic [LIM_W-1:0]    eff_ent;
   logic [LIM_W-1:0]    cap_pool;
   logic [LIM_W-1:0]    eff_cap;
   logic [HANDLE_W-1:0] req_handle;
   logic [CNT_W-1:0]    enc_slot;
   logic [CNT_W-1:0]    last_slot;

   logic                map_we;
   logic [MAW-1:0]      map_waddr;
   logic [CNT_W-1:0]    map_wdata;
   logic                map_re;
   logic [MAW-1:0]      map_raddr;
   logic                dense_we;
   logic [PW-1:0]       dense_waddr;
   logic [HANDLE_W-1:0] dense_wdata;
   logic                dense_re;
   logic [PW-1:0]       dense_raddr;

   function automatic logic [XW-1:0] idx_of(input logic [HANDLE_W-1:0] h);
      return XW'(h[INDEX_BITS-1:0]);
   endfunction

   function automatic logic [MAW-1:0] map_addr(input logic [HANDLE_W-1:0] h);
      logic [XW-1:0] ix;
      ix = idx_of(h);
      return ix[MAW-1:0];
   endfunction

   function automatic logic fits(input logic [HANDLE_W-1:0] h,
                                 input logic [LIM_W-1:0]    lim);
      return (|h[HANDLE_W-1:INDEX_BITS]) && (idx_of(h) < XW'(lim));
   endfunction

   // effective limits
   always_comb begin
      eff_ent  = (LIM_W'(entity_limit_ff) < LIM_W'(IDX_LIM)) ?
                 LIM_W'(entity_limit_ff) : LIM_W'(IDX_LIM);
      cap_pool = (LIM_W'(pool_capacity_ff) < LIM_W'(POOL_CAP)) ?
                 LIM_W'(pool_capacity_ff) : LIM_W'(POOL_CAP);
      eff_cap  = (cap_pool < eff_ent) ? cap_pool : eff_ent;
   end

   assign req_handle = req_entity_handle & HMASK;
   assign enc_slot   = map_rd_ff - CNT_W'(1);
   assign last_slot  = count_ff - CNT_W'(1);

   // status toward the controller
   always_comb begin
      status.clear_last   = (clr_ff == MAW'(ENTITY_CAP - 1));
      status.rsp_free     = !rsp_valid_ff || !rsp_stall;
      status.cmd_query    = (cmd_ff == CMD_QUERY);
      status.cmd_add      = (cmd_ff == CMD_ADD);
      status.cmd_remove   = (cmd_ff == CMD_REMOVE);
      status.fits         = fits(handle_ff, eff_ent);
      status.enc_zero     = (map_rd_ff == '0);
      status.hit_range    = (map_rd_ff != '0) && (enc_slot < count_ff) &&
                            (LIM_W'(enc_slot) < eff_cap) &&
                            (enc_slot < CNT_W'(POOL_CAP));
      status.room         = (LIM_W'(count_ff) < eff_cap);
      status.dense_match  = (dense_rd_ff == handle_ff);
      status.slot_is_last = (slot_ff == last_slot);
      status.moved_fits   = fits(dense_rd_ff, eff_ent);
      status.moved_map_ok = (map_rd_ff == count_ff);
   end

   // memory port selection
   always_comb begin
      map_we      = 1'b0;
      map_waddr   = map_addr(handle_ff);
      map_wdata   = '0;
      map_re      = 1'b0;
      map_raddr   = map_addr(handle_ff);
      dense_we    = 1'b0;
      dense_waddr = PW'(slot_ff);
      dense_wdata = handle_ff;
      dense_re    = 1'b0;
      dense_raddr = PW'(slot_ff);
      unique case (cmd.op)
         OP_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
         end
         OP_TAKE: begin
            map_re    = 1'b1;
            map_raddr = map_addr(req_handle);
         end
         OP_RD_SLOT: begin
            dense_re    = 1'b1;
            dense_raddr = PW'(enc_slot);
         end
         OP_ADD: begin
            dense_we    = 1'b1;
            dense_waddr = PW'(count_ff);
            map_we      = 1'b1;
            map_wdata   = count_ff + CNT_W'(1);
         end
         OP_DROP_LAST: begin
            map_we = 1'b1;
         end
         OP_RD_LAST: begin
            dense_re    = 1'b1;
            dense_raddr = PW'(last_slot);
         end
         OP_RD_MOVED: begin
            map_re    = 1'b1;
            map_raddr = map_addr(dense_rd_ff);
         end
         OP_SWAP: begin
            dense_we    = 1'b1;
            dense_wdata = moved_ff;
            map_we      = 1'b1;
            map_waddr   = map_addr(moved_ff);
            map_wdata   = slot_ff + CNT_W'(1);
         end
         OP_UNMAP: begin
            map_we = 1'b1;
         end
         OP_NONE, OP_HIT, OP_LOAD: begin
         end
         default: begin
         end
      endcase
   end

   // sparse map memory
   always_ff @(posedge clock) begin
      if (map_we) begin
         sparse_map_ff[map_waddr] <= map_wdata;
      end
      if (map_re) begin
         map_rd_ff <= sparse_map_ff[map_raddr];
      end
   end

   // dense handle memory
   always_ff @(posedge clock) begin
      if (dense_we) begin
         dense_handles_ff[dense_waddr] <= dense_wdata;
      end
      if (dense_re) begin
         dense_rd_ff <= dense_handles_ff[dense_raddr];
      end
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         entity_limit_ff  <= CFG_W'(1024);
         pool_capacity_ff <= CFG_W'(1024);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENTITY_LIMIT:  entity_limit_ff  <= csr_write_data;
            CSR_POOL_CAPACITY: pool_capacity_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // control registers: clear sweep and live count
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.op == OP_CLEAR) begin
            clr_ff <= clr_ff + MAW'(1);
         end
         if (cmd.op == OP_ADD) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.op == OP_DROP_LAST || cmd.op == OP_SWAP) begin
            count_ff <= last_slot;
         end
      end
   end

   // working word and result fields
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_TAKE: begin
            cmd_ff       <= req_command;
            handle_ff    <= req_handle;
            res_ok_ff    <= 1'b0;
            res_pos_ff   <= '0;
            res_from_ff  <= '0;
            res_moved_ff <= '0;
         end
         OP_RD_SLOT: begin
            slot_ff <= enc_slot;
         end
         OP_HIT: begin
            res_ok_ff  <= 1'b1;
            res_pos_ff <= slot_ff;
         end
         OP_ADD: begin
            res_ok_ff  <= 1'b1;
            res_pos_ff <= count_ff;
         end
         OP_DROP_LAST: begin
            res_ok_ff   <= 1'b1;
            res_pos_ff  <= slot_ff;
            res_from_ff <= slot_ff;
         end
         OP_RD_MOVED: begin
            moved_ff <= dense_rd_ff;
         end
         OP_SWAP: begin
            res_ok_ff    <= 1'b1;
            res_pos_ff   <= slot_ff;
            res_from_ff  <= last_slot;
            res_moved_ff <= moved_ff;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_pos_ff   <= POS_W'(res_pos_ff);
         rsp_from_ff  <= POS_W'(res_from_ff);
         rsp_moved_ff <= res_moved_ff;
         rsp_live_ff  <= LIVE_W'(count_ff);
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_ok                  = rsp_ok_ff;
   assign rsp_dense_position      = rsp_pos_ff;
   assign rsp_moved_from_position = rsp_from_ff;
   assign rsp_moved_handle        = rsp_moved_ff;
   assign rsp_live_count          = rsp_live_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_CAP))
      else $error("live count above pool size");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |->
         (rsp_pos_ff == '0 && rsp_from_ff == '0 && rsp_moved_ff == '0))
      else $error("rejected word carries nonzero fields");

   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DROP_LAST || cmd.op == OP_SWAP) |=>
         (count_ff == CNT_W'($past(count_ff) - CNT_W'(1))))
      else $error("remove did not drop live count by one");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

endmodule
